FILE: design/gras_pkg.sv
package gras_pkg;

  localparam int MAX_RES   = 64;
  localparam int FRAC_BITS = 12;

  localparam int COEF_W  = 16;
  localparam int TRANS_W = 24;
  localparam int GRID_W  = 7;
  localparam int CH_W    = 32;
  localparam int IDX_W   = 12;

  localparam int CNT_W  = $clog2(MAX_RES);
  localparam int N_W    = $clog2(MAX_RES + 1);
  localparam int D_W    = CNT_W + 2;
  localparam int P_W    = D_W + COEF_W;
  localparam int T2_W   = TRANS_W + 1;
  localparam int CTR_W  = CNT_W + FRAC_BITS + 1;
  localparam int SMAX_W = (P_W > T2_W) ? ((P_W > CTR_W) ? P_W : CTR_W)
                                       : ((T2_W > CTR_W) ? T2_W : CTR_W);
  localparam int S_W    = SMAX_W + 2;
  localparam int X_W    = CNT_W + FRAC_BITS + 1;
  localparam int LIM_W  = X_W + 1;
  localparam int LIN_W  = X_W + N_W + 1;
  localparam int IDX_SH = FRAC_BITS + 1;

  localparam int IN_DATA_W  = ((3 * CH_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((IDX_W + 3 * CH_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 3'd6;

  localparam logic signed [COEF_W-1:0] RST_COEF_DIAG = 16'sd4096;
  localparam logic [GRID_W-1:0]        RST_GRID_SIZE = 7'd64;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [COEF_W-1:0]  coef_xx;
    logic signed [COEF_W-1:0]  coef_xy;
    logic signed [TRANS_W-1:0] trans_x;
    logic signed [COEF_W-1:0]  coef_yx;
    logic signed [COEF_W-1:0]  coef_yy;
    logic signed [TRANS_W-1:0] trans_y;
    logic [GRID_W-1:0]         grid_size;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic            last;
  } pass_t;

  typedef struct packed {
    logic signed [D_W-1:0] dx2;
    logic signed [D_W-1:0] dy2;
    logic [N_W-1:0]        n;
    pass_t                 pass;
  } item_t;

endpackage

FILE: design/gras_front.sv
module gras_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gras_pkg::CH_W-1:0]    in_r,
  input  logic [gras_pkg::CH_W-1:0]    in_g,
  input  logic [gras_pkg::CH_W-1:0]    in_b,
  input  logic [gras_pkg::GRID_W-1:0]  grid_size,
  input  logic                         q_full,
  output logic                         q_push,
  output gras_pkg::item_t              q_item
);

  logic [gras_pkg::CNT_W-1:0] col_count;
  logic [gras_pkg::CNT_W-1:0] row_count;
  logic [gras_pkg::N_W-1:0]   n;
  logic [gras_pkg::N_W-1:0]   nm1;
  logic                       row_end;
  logic                       grid_end;

  // grid side saturated to 1..MAX_RES
  always_comb begin
    if (grid_size == '0) begin
      n = gras_pkg::N_W'(1);
    end else if (gras_pkg::N_W'(grid_size) > gras_pkg::N_W'(gras_pkg::MAX_RES)) begin
      n = gras_pkg::N_W'(gras_pkg::MAX_RES);
    end else begin
      n = gras_pkg::N_W'(grid_size);
    end
  end

  assign nm1      = n - gras_pkg::N_W'(1);
  assign row_end  = gras_pkg::N_W'(col_count) >= nm1;
  assign grid_end = row_end && (gras_pkg::N_W'(row_count) >= nm1);

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // offsets in half-cell units: 2*pos - (n-1)
  always_comb begin
    q_item.dx2       = $signed({1'b0, col_count, 1'b0}) - $signed({1'b0, nm1});
    q_item.dy2       = $signed({1'b0, row_count, 1'b0}) - $signed({1'b0, nm1});
    q_item.n         = n;
    q_item.pass.r    = in_r;
    q_item.pass.g    = in_g;
    q_item.pass.b    = in_b;
    q_item.pass.last = grid_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (q_push) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= grid_end ? '0 : row_count + gras_pkg::CNT_W'(1);
      end else begin
        col_count <= col_count + gras_pkg::CNT_W'(1);
      end
    end
  end

endmodule

FILE: design/gras_queue.sv
module gras_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gras_pkg::item_t push_item,
  input  logic            pop,
  output gras_pkg::item_t head,
  output logic            full,
  output logic            empty
);

  gras_pkg::item_t              mem [gras_pkg::FIFO_DEPTH];
  logic [gras_pkg::PTR_W-1:0]   wr_ptr;
  logic [gras_pkg::PTR_W-1:0]   rd_ptr;
  logic [gras_pkg::FCNT_W-1:0]  count;

  assign full  = count == gras_pkg::FCNT_W'(gras_pkg::FIFO_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + gras_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + gras_pkg::PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + gras_pkg::FCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - gras_pkg::FCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= gras_pkg::FCNT_W'(gras_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

FILE: design/gras_back.sv
module gras_back (
  input  logic                              clk,
  input  logic                              rst,
  input  gras_pkg::cfg_t                    cfg,
  input  logic                              q_empty,
  input  gras_pkg::item_t                   q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gras_pkg::IDX_W-1:0]        out_dest,
  output gras_pkg::pass_t                   out_pass,
  output logic                              out_oor
);

  logic adv;

  logic                           s1_valid;
  logic signed [gras_pkg::P_W-1:0] s1_pxx, s1_pxy, s1_pyx, s1_pyy;
  logic signed [gras_pkg::S_W-1:0] s1_ox, s1_oy;
  logic [gras_pkg::N_W-1:0]        s1_n;
  gras_pkg::pass_t                 s1_pass;

  logic                            s2_valid;
  logic signed [gras_pkg::S_W-1:0] s2_x, s2_y;
  logic [gras_pkg::LIM_W-1:0]      s2_lim;
  logic [gras_pkg::N_W-1:0]        s2_n;
  gras_pkg::pass_t                 s2_pass;

  logic                                    s3_valid;
  logic                                    s3_oor;
  logic [gras_pkg::X_W+gras_pkg::N_W-1:0]  s3_prod;
  logic [gras_pkg::X_W-1:0]                s3_xlo;
  gras_pkg::pass_t                         s3_pass;

  logic [gras_pkg::S_W-1:0]        ctr;
  logic signed [gras_pkg::S_W-1:0] tx_ext, ty_ext;
  logic signed [gras_pkg::S_W-1:0] lim_s;
  logic                            oor;
  logic [gras_pkg::LIN_W-1:0]      lin;
  logic [gras_pkg::LIN_W-1:0]      lin_sh;

  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;

  assign ctr    = gras_pkg::S_W'(q_head.n - gras_pkg::N_W'(1)) << gras_pkg::FRAC_BITS;
  assign tx_ext = gras_pkg::S_W'(cfg.trans_x);
  assign ty_ext = gras_pkg::S_W'(cfg.trans_y);

  assign lim_s = $signed(gras_pkg::S_W'(s2_lim));
  assign oor   = (s2_x < 0) || (s2_x >= lim_s) || (s2_y < 0) || (s2_y >= lim_s);

  assign lin    = gras_pkg::LIN_W'(s3_prod) + gras_pkg::LIN_W'(s3_xlo);
  assign lin_sh = lin >> gras_pkg::IDX_SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= !q_empty;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // products, plus translation and centre in half-LSB units
      s1_pxx  <= q_head.dx2 * cfg.coef_xx;
      s1_pxy  <= q_head.dy2 * cfg.coef_xy;
      s1_pyx  <= q_head.dx2 * cfg.coef_yx;
      s1_pyy  <= q_head.dy2 * cfg.coef_yy;
      s1_ox   <= (tx_ext <<< 1) + $signed(ctr);
      s1_oy   <= (ty_ext <<< 1) + $signed(ctr);
      s1_n    <= q_head.n;
      s1_pass <= q_head.pass;

      s2_x    <= gras_pkg::S_W'(s1_pxx) + gras_pkg::S_W'(s1_pxy) + s1_ox;
      s2_y    <= gras_pkg::S_W'(s1_pyx) + gras_pkg::S_W'(s1_pyy) + s1_oy;
      s2_lim  <= gras_pkg::LIM_W'(s1_n) << gras_pkg::IDX_SH;
      s2_n    <= s1_n;
      s2_pass <= s1_pass;

      s3_oor  <= oor;
      s3_prod <= s2_y[gras_pkg::X_W-1:0] * s2_n;
      s3_xlo  <= s2_x[gras_pkg::X_W-1:0];
      s3_pass <= s2_pass;

      out_oor  <= s3_oor;
      out_dest <= s3_oor ? '0 : gras_pkg::IDX_W'(lin_sh);
      out_pass <= s3_pass;
    end
  end

  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> s1_valid)
    else $error("popped beat not in first stage");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    adv && s3_valid |=> out_valid)
    else $error("beat lost at output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s1_valid) && $stable(s2_valid) && $stable(s3_valid))
    else $error("pipeline moved while stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_oor |-> out_dest == '0)
    else $error("out of range with nonzero index");

endmodule

FILE: design/grid_rotation_scatter_address.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: in_r, in_g, in_b
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: dest_index, out_r/g/b;
//                                               tuser: out_of_range; tlast: last_cell
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// Sustained rate is one beat per cycle while m_axis_tready is high; an input beat
// passes queue write, product stage, sum stage, row*size multiply and output reg.
// Reset (rst, synchronous) loads the register reset values, zeroes the raster
// counters and empties the 4-entry queue. cfg_ready is always high.
// m_axis_tready low freezes the back pipeline; the queue then absorbs up to
// 4 beats before s_axis_tready drops.
module grid_rotation_scatter_address (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] in_r, [63:32] in_g, [95:64] in_b
  input  logic [gras_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [11:0] dest_index, [43:12] out_r, [75:44] out_g, [107:76] out_b, rest zero
  output logic [gras_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [0] out_of_range
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gras_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gras_pkg::CFG_DATA_W-1:0]   cfg_data
);

  gras_pkg::cfg_t  cfg;
  gras_pkg::item_t push_item;
  gras_pkg::item_t head;
  gras_pkg::pass_t out_pass;
  logic            q_push, q_pop, q_full, q_empty;
  logic [gras_pkg::IDX_W-1:0] out_dest;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_xx   <= gras_pkg::RST_COEF_DIAG;
      cfg.coef_xy   <= '0;
      cfg.trans_x   <= '0;
      cfg.coef_yx   <= '0;
      cfg.coef_yy   <= gras_pkg::RST_COEF_DIAG;
      cfg.trans_y   <= '0;
      cfg.grid_size <= gras_pkg::RST_GRID_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gras_pkg::REG_COEF_XX:   cfg.coef_xx   <= cfg_data[gras_pkg::COEF_W-1:0];
        gras_pkg::REG_COEF_XY:   cfg.coef_xy   <= cfg_data[gras_pkg::COEF_W-1:0];
        gras_pkg::REG_TRANS_X:   cfg.trans_x   <= cfg_data[gras_pkg::TRANS_W-1:0];
        gras_pkg::REG_COEF_YX:   cfg.coef_yx   <= cfg_data[gras_pkg::COEF_W-1:0];
        gras_pkg::REG_COEF_YY:   cfg.coef_yy   <= cfg_data[gras_pkg::COEF_W-1:0];
        gras_pkg::REG_TRANS_Y:   cfg.trans_y   <= cfg_data[gras_pkg::TRANS_W-1:0];
        gras_pkg::REG_GRID_SIZE: cfg.grid_size <= cfg_data[gras_pkg::GRID_W-1:0];
        default: ;
      endcase
    end
  end

  gras_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_r      (s_axis_tdata[gras_pkg::CH_W-1:0]),
    .in_g      (s_axis_tdata[2*gras_pkg::CH_W-1:gras_pkg::CH_W]),
    .in_b      (s_axis_tdata[3*gras_pkg::CH_W-1:2*gras_pkg::CH_W]),
    .grid_size (cfg.grid_size),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  gras_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  gras_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_dest  (out_dest),
    .out_pass  (out_pass),
    .out_oor   (m_axis_tuser)
  );

  assign m_axis_tdata = gras_pkg::OUT_DATA_W'({out_pass.b, out_pass.g, out_pass.r, out_dest});
  assign m_axis_tlast = out_pass.last;

endmodule
